@@ hdl/mmf_pkg.sv @@
// Shared types and constants for the MIDI message framer.
`default_nettype none

package mmf_pkg;

  // Status byte codes
  localparam logic [7:0] ST_NOTE_OFF  = 8'h80;  // lowest status byte
  localparam logic [7:0] ST_PROG      = 8'hC0;
  localparam logic [7:0] ST_CHPRESS   = 8'hD0;
  localparam logic [7:0] ST_SYSEX     = 8'hF0;
  localparam logic [7:0] ST_MTC       = 8'hF1;
  localparam logic [7:0] ST_SPP       = 8'hF2;
  localparam logic [7:0] ST_SONG_SEL  = 8'hF3;
  localparam logic [7:0] ST_EOX       = 8'hF7;
  localparam logic [7:0] ST_CLOCK     = 8'hF8;  // lowest realtime byte

  // SysEx record size: default and largest supported
  localparam int SYSEX_CHUNK_DEF = 32;
  localparam int SYSEX_CHUNK_MAX = 64;

  // Most words emitted for one input byte
  localparam int MAX_RESULTS = 32;

  localparam int LEN_W = $clog2(SYSEX_CHUNK_MAX + 1);
  localparam int CNT_W = $clog2(MAX_RESULTS + 1);

  // Command queue depth (power of two)
  localparam int QDEPTH = 2;

  // One emit command: a sysex record from the buffer, then a short record
  typedef struct packed {
    logic [LEN_W-1:0] sx_len;   // sysex bytes to drain, 0 for none
    logic [1:0]       sh_len;   // short record bytes, 0 for none
    logic [CNT_W-1:0] total;    // words to emit, capped
    logic [7:0]       b0;
    logic [7:0]       b1;
    logic [7:0]       b2;
  } cmd_t;

endpackage

`default_nettype wire

@@ hdl/mmf_front.sv @@
// Front end: accepts MIDI bytes, tracks parse state and issues emit commands.
`default_nettype none

module mmf_front #(
  parameter int SYSEX_CHUNK = mmf_pkg::SYSEX_CHUNK_DEF
) (
  input  wire                            clk,
  input  wire                            rst_n,
  input  wire                            in_valid,
  output logic                           in_stall,
  input  wire  [7:0]                     in_byte,
  output logic                           cmd_push,
  output mmf_pkg::cmd_t                  cmd,
  input  wire                            cmd_full,
  input  wire                            sx_done,
  output logic                           sx_we,
  output logic [$clog2(SYSEX_CHUNK)-1:0] sx_waddr,
  output logic [7:0]                     sx_wdata
);
  import mmf_pkg::*;

  localparam int AW = $clog2(SYSEX_CHUNK);
  localparam int FW = $clog2(SYSEX_CHUNK + 1);

  // Message length from its status byte
  function automatic logic [1:0] msg_len(input logic [7:0] s);
    logic [1:0] len;
    if (s < ST_SYSEX) begin
      if ((s & 8'hF0) == ST_PROG || (s & 8'hF0) == ST_CHPRESS) len = 2'd2;
      else len = 2'd3;
    end else if (s == ST_MTC || s == ST_SONG_SEL) begin
      len = 2'd2;
    end else if (s == ST_SPP) begin
      len = 2'd3;
    end else begin
      len = 2'd1;
    end
    return len;
  endfunction

  logic          in_sysex_r, in_sysex_nxt;
  logic [FW-1:0] sx_fill_r, sx_fill_nxt;
  logic [1:0]    sh_fill_r, sh_fill_nxt;
  logic [7:0]    rs_r, rs_nxt;
  logic [7:0]    sh0_r, sh0_nxt, sh1_r, sh1_nxt, sh2_r, sh2_nxt;
  logic          pend_r, pend_nxt;

  logic              acc;
  logic              do_short;
  logic              drop;
  logic [FW-1:0]     nf;
  logic [1:0]        f;
  logic [1:0]        want;
  logic [7:0]        s0;
  logic [LEN_W:0]    sum;

  // Hold off while a sysex drain reads the buffer or the queue is full
  assign in_stall = pend_r || cmd_full;
  assign acc      = in_valid && !in_stall;

  // Parse one byte
  always_comb begin
    in_sysex_nxt = in_sysex_r;
    sx_fill_nxt  = sx_fill_r;
    sh_fill_nxt  = sh_fill_r;
    rs_nxt       = rs_r;
    sh0_nxt      = sh0_r;
    sh1_nxt      = sh1_r;
    sh2_nxt      = sh2_r;
    cmd          = '0;
    sx_we        = 1'b0;
    sx_waddr     = sx_fill_r[AW-1:0];
    sx_wdata     = in_byte;
    do_short     = 1'b0;
    drop         = 1'b0;
    nf           = sx_fill_r;
    f            = sh_fill_r;
    s0           = sh0_r;
    want         = 2'd1;
    if (acc) begin
      if (in_byte >= ST_CLOCK) begin
        // realtime passes straight through
        cmd.sh_len = 2'd1;
        cmd.b0     = in_byte;
      end else if (in_byte == ST_SYSEX) begin
        // new sysex drops any unflushed buffer
        sh_fill_nxt  = 2'd0;
        rs_nxt       = 8'h00;
        in_sysex_nxt = 1'b1;
        sx_we        = 1'b1;
        sx_waddr     = '0;
        sx_fill_nxt  = FW'(1);
      end else begin
        do_short = 1'b1;
        if (in_sysex_r) begin
          if (in_byte == ST_EOX) begin
            if (sx_fill_r < FW'(SYSEX_CHUNK)) begin
              sx_we = 1'b1;
              nf    = sx_fill_r + FW'(1);
            end
            cmd.sx_len   = LEN_W'(nf);
            sx_fill_nxt  = '0;
            in_sysex_nxt = 1'b0;
            do_short     = 1'b0;
          end else if (in_byte[7]) begin
            // interrupting status: flush then parse it
            cmd.sx_len   = LEN_W'(sx_fill_r);
            sx_fill_nxt  = '0;
            in_sysex_nxt = 1'b0;
          end else begin
            if (sx_fill_r < FW'(SYSEX_CHUNK)) begin
              sx_we = 1'b1;
              nf    = sx_fill_r + FW'(1);
            end
            if (nf >= FW'(SYSEX_CHUNK)) begin
              cmd.sx_len  = LEN_W'(nf);
              sx_fill_nxt = '0;
            end else begin
              sx_fill_nxt = nf;
            end
            do_short = 1'b0;
          end
        end
        if (do_short) begin
          if (in_byte[7]) begin
            // status byte
            sh0_nxt     = in_byte;
            sh_fill_nxt = 2'd1;
            rs_nxt      = (in_byte < ST_SYSEX) ? in_byte : 8'h00;
            if (msg_len(in_byte) == 2'd1) begin
              cmd.sh_len  = 2'd1;
              cmd.b0      = in_byte;
              sh_fill_nxt = 2'd0;
            end
          end else begin
            // data byte, resume running status if no partial message
            if (f == 2'd0) begin
              if (rs_r == 8'h00) begin
                drop = 1'b1;
              end else begin
                s0 = rs_r;
                f  = 2'd1;
              end
            end
            if (!drop) begin
              sh0_nxt = s0;
              if (f == 2'd2) sh2_nxt = in_byte;
              else sh1_nxt = in_byte;
              f    = f + 2'd1;
              want = msg_len(s0);
              if (f >= want) begin
                cmd.sh_len  = want;
                cmd.b0      = s0;
                cmd.b1      = sh1_nxt;
                cmd.b2      = sh2_nxt;
                sh_fill_nxt = 2'd0;
              end else begin
                sh_fill_nxt = f;
              end
            end
          end
        end
      end
    end
    sum       = {1'b0, cmd.sx_len} + (LEN_W + 1)'(cmd.sh_len);
    cmd.total = (sum > (LEN_W + 1)'(MAX_RESULTS)) ? CNT_W'(MAX_RESULTS) : CNT_W'(sum);
    cmd_push  = acc && (sum != '0);
  end

  // Drain guard: set on a sysex command, cleared when the back end finishes it
  always_comb begin
    pend_nxt = pend_r;
    if (sx_done) pend_nxt = 1'b0;
    if (cmd_push && cmd.sx_len != '0) pend_nxt = 1'b1;
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_sysex_r <= 1'b0;
      sx_fill_r  <= '0;
      sh_fill_r  <= 2'd0;
      rs_r       <= 8'h00;
      pend_r     <= 1'b0;
    end else begin
      in_sysex_r <= in_sysex_nxt;
      sx_fill_r  <= sx_fill_nxt;
      sh_fill_r  <= sh_fill_nxt;
      rs_r       <= rs_nxt;
      pend_r     <= pend_nxt;
    end
  end

  // Short message bytes
  always_ff @(posedge clk) begin
    sh0_r <= sh0_nxt;
    sh1_r <= sh1_nxt;
    sh2_r <= sh2_nxt;
  end

endmodule

`default_nettype wire

@@ hdl/mmf_cmd_fifo.sv @@
// Small command queue between the front and back ends.
`default_nettype none

module mmf_cmd_fifo (
  input  wire           clk,
  input  wire           rst_n,
  input  wire           push,
  input  mmf_pkg::cmd_t din,
  output logic          full,
  input  wire           pop,
  output mmf_pkg::cmd_t dout,
  output logic          empty
);
  import mmf_pkg::*;

  localparam int PW = $clog2(QDEPTH);

  cmd_t          slot_r [QDEPTH];
  logic [PW-1:0] wp_r, rp_r;
  logic [PW:0]   cnt_r;

  assign full  = (cnt_r == (PW + 1)'(QDEPTH));
  assign empty = (cnt_r == '0);
  assign dout  = slot_r[rp_r];

  // Pointers and count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + PW'(1);
      if (pop)  rp_r <= rp_r + PW'(1);
      if (push && !pop)      cnt_r <= cnt_r + (PW + 1)'(1);
      else if (pop && !push) cnt_r <= cnt_r - (PW + 1)'(1);
    end
  end

  // Storage
  always_ff @(posedge clk) begin
    if (push) slot_r[wp_r] <= din;
  end

endmodule

`default_nettype wire

@@ hdl/mmf_back.sv @@
// Back end: holds the sysex buffer and emits command records as output words.
`default_nettype none

module mmf_back #(
  parameter int SYSEX_CHUNK = mmf_pkg::SYSEX_CHUNK_DEF
) (
  input  wire                            clk,
  input  wire                            rst_n,
  input  wire                            cmd_empty,
  input  mmf_pkg::cmd_t                  cmd,
  output logic                           cmd_pop,
  input  wire                            sx_we,
  input  wire  [$clog2(SYSEX_CHUNK)-1:0] sx_waddr,
  input  wire  [7:0]                     sx_wdata,
  output logic                           sx_done,
  output logic                           out_valid,
  input  wire                            out_stall,
  output logic [7:0]                     out_byte,
  output logic                           out_record_last,
  output logic                           out_run_last
);
  import mmf_pkg::*;

  localparam int AW = $clog2(SYSEX_CHUNK);

  typedef enum logic [1:0] {B_IDLE, B_SXRD, B_SXOUT, B_SH} state_t;

  state_t           state_r;
  cmd_t             cur_r;
  logic [CNT_W-1:0] k_r;
  logic [AW-1:0]    idx_r;
  logic [1:0]       j_r;
  logic [7:0]       mem [SYSEX_CHUNK];
  logic [7:0]       rd_data_r;
  logic             out_valid_r, rec_r, run_r, sx_done_r;
  logic [7:0]       out_byte_r;

  logic       out_free;
  logic       emit;
  logic       k_last, idx_last, j_last;
  logic [7:0] sh_byte;

  assign out_free = !out_valid_r || !out_stall;
  assign emit     = out_free && (state_r == B_SXOUT || state_r == B_SH);
  assign cmd_pop  = (state_r == B_IDLE) && !cmd_empty;
  assign k_last   = (k_r == cur_r.total - CNT_W'(1));
  assign idx_last = (LEN_W'(idx_r) == cur_r.sx_len - LEN_W'(1));
  assign j_last   = (j_r == cur_r.sh_len - 2'd1);

  // Short record byte select
  always_comb begin
    case (j_r)
      2'd0:    sh_byte = cur_r.b0;
      2'd1:    sh_byte = cur_r.b1;
      default: sh_byte = cur_r.b2;
    endcase
  end

  // SysEx buffer, registered read
  always_ff @(posedge clk) begin
    if (sx_we) mem[sx_waddr] <= sx_wdata;
    rd_data_r <= mem[idx_r];
  end

  // Emit sequencer and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      out_valid_r <= 1'b0;
      sx_done_r   <= 1'b0;
    end else begin
      // done pulses with the last word of a command that drained the buffer
      sx_done_r <= emit && k_last && (cur_r.sx_len != '0);
      if (emit) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
      unique case (state_r)
        B_IDLE: begin
          if (!cmd_empty) begin
            cur_r   <= cmd;
            k_r     <= '0;
            idx_r   <= '0;
            j_r     <= 2'd0;
            state_r <= (cmd.sx_len != '0) ? B_SXRD : B_SH;
          end
        end
        B_SXRD: begin
          state_r <= B_SXOUT;
        end
        B_SXOUT: begin
          if (out_free) begin
            out_byte_r  <= rd_data_r;
            rec_r       <= idx_last;
            run_r       <= k_last;
            k_r         <= k_r + CNT_W'(1);
            idx_r       <= idx_r + AW'(1);
            if (k_last) begin
              state_r <= B_IDLE;
            end else if (idx_last) begin
              state_r <= B_SH;
            end else begin
              state_r <= B_SXRD;
            end
          end
        end
        B_SH: begin
          if (out_free) begin
            out_byte_r  <= sh_byte;
            rec_r       <= j_last;
            run_r       <= k_last;
            k_r         <= k_r + CNT_W'(1);
            j_r         <= j_r + 2'd1;
            if (k_last) begin
              state_r <= B_IDLE;
            end
          end
        end
        default: state_r <= B_IDLE;
      endcase
    end
  end

  assign out_valid       = out_valid_r;
  assign out_byte        = out_byte_r;
  assign out_record_last = rec_r;
  assign out_run_last    = run_r;
  assign sx_done         = sx_done_r;

endmodule

`default_nettype wire

@@ hdl/midi_message_framer_core.sv @@
// Top level of the MIDI message framer: front end, command queue, back end.
// A one-byte or short message is queued, loaded by the back end, then registered out.
// Throughput: one input byte per cycle while the queue has room; words leave one per
// cycle within a short record unless the output stalls; the back end idles between
// commands; a buffer read precedes each sysex word. Input stalls while sysex drains.
// Reset: synchronous, clears parse state, queue and output; buffer needs no clearing.
`default_nettype none

module midi_message_framer_core #(
  parameter int SYSEX_CHUNK = mmf_pkg::SYSEX_CHUNK_DEF
) (
  input  wire        clk,
  input  wire        rst_n,
  input  wire        in_valid,
  output logic       in_stall,
  input  wire  [7:0] in_byte,
  output logic       out_valid,
  input  wire        out_stall,
  output logic [7:0] out_byte,
  output logic       out_record_last,
  output logic       out_run_last
);
  import mmf_pkg::*;

  localparam int AW = $clog2(SYSEX_CHUNK);

  cmd_t          push_cmd, pop_cmd;
  logic          cmd_push, cmd_pop, cmd_full, cmd_empty;
  logic          sx_done, sx_we;
  logic [AW-1:0] sx_waddr;
  logic [7:0]    sx_wdata;

  mmf_front #(.SYSEX_CHUNK(SYSEX_CHUNK)) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_byte  (in_byte),
    .cmd_push (cmd_push),
    .cmd      (push_cmd),
    .cmd_full (cmd_full),
    .sx_done  (sx_done),
    .sx_we    (sx_we),
    .sx_waddr (sx_waddr),
    .sx_wdata (sx_wdata)
  );

  mmf_cmd_fifo u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (cmd_push),
    .din   (push_cmd),
    .full  (cmd_full),
    .pop   (cmd_pop),
    .dout  (pop_cmd),
    .empty (cmd_empty)
  );

  mmf_back #(.SYSEX_CHUNK(SYSEX_CHUNK)) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd_empty       (cmd_empty),
    .cmd             (pop_cmd),
    .cmd_pop         (cmd_pop),
    .sx_we           (sx_we),
    .sx_waddr        (sx_waddr),
    .sx_wdata        (sx_wdata),
    .sx_done         (sx_done),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_byte        (out_byte),
    .out_record_last (out_record_last),
    .out_run_last    (out_run_last)
  );

endmodule

`default_nettype wire

@@ hdl/mmf_checker.sv @@
// Port-level checks for the MIDI message framer, bound to the top level.
`default_nettype none

module mmf_checker (
  input wire       clk,
  input wire       rst_n,
  input wire       in_valid,
  input wire       in_stall,
  input wire [7:0] in_byte,
  input wire       out_valid,
  input wire       out_stall,
  input wire [7:0] out_byte,
  input wire       out_record_last,
  input wire       out_run_last
);
  import mmf_pkg::*;

  // Reset empties the output register
  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output word valid after reset");

  // A stalled output word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_byte)
      && $stable(out_record_last) && $stable(out_run_last))
    else $error("stalled output word changed");

  // A sysex start queues nothing, so input stays open
  a_sysex_no_stall: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_byte == ST_SYSEX |=> !in_stall)
    else $error("input stalled after sysex start");

endmodule

bind midi_message_framer_core mmf_checker u_mmf_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_stall        (in_stall),
  .in_byte         (in_byte),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_byte        (out_byte),
  .out_record_last (out_record_last),
  .out_run_last    (out_run_last)
);

`default_nettype wire

@@ tb/sv/midi_message_framer_core_tb.sv @@
// Self-checking testbench for the MIDI message framer core.
`timescale 1ns / 1ps

module midi_message_framer_core_tb;
  import mmf_pkg::*;

  localparam int SX_CHUNK = SYSEX_CHUNK_DEF;
  localparam int DRAIN_LIMIT = 20000;
  localparam int SETTLE_CYCLES = 20;
  localparam int RANDOM_PER_PHASE = 90;

  // One word on the result channel
  typedef struct packed {
    logic [7:0] data;
    logic       rec_last;
    logic       run_last;
  } midi_word_t;

  logic       clk = 1'b0;
  logic       rst_n;
  logic       in_valid;
  logic       in_stall;
  logic [7:0] in_byte;
  logic       out_valid;
  logic       out_stall;
  logic [7:0] out_byte;
  logic       out_record_last;
  logic       out_run_last;

  // Pacing knobs, percent of cycles
  int send_idle_pct = 0;
  int recv_stall_pct = 0;

  // Bookkeeping
  midi_word_t expected_words[$];
  midi_word_t step_words[$];
  int mismatches = 0;
  int bytes_sent = 0;
  int counted_bytes = 0;
  int words_checked = 0;
  int records_checked = 0;

  // Parser state mirror
  logic       sx_active = 1'b0;
  logic [7:0] sx_buf[SYSEX_CHUNK_MAX];
  int         sx_fill = 0;
  logic [7:0] msg_buf[3];
  int         msg_fill = 0;
  logic [7:0] run_status = 8'h00;
  logic       byte_dropped;

  midi_message_framer_core #(.SYSEX_CHUNK(SX_CHUNK)) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_byte(in_byte),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_byte(out_byte),
    .out_record_last(out_record_last),
    .out_run_last(out_run_last)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Framing predictor
  // ---------------------------------------------------------------------------

  // Bytes in a message that starts with status s
  function automatic int msg_length(input logic [7:0] s);
    if (s < ST_SYSEX) begin
      return (s[7:4] == ST_PROG[7:4] || s[7:4] == ST_CHPRESS[7:4]) ? 2 : 3;
    end
    if (s == ST_MTC || s == ST_SONG_SEL) return 2;
    if (s == ST_SPP) return 3;
    return 1;
  endfunction

  // Words beyond the per-byte cap are lost
  function automatic void emit_word(input logic [7:0] b, input logic last);
    midi_word_t w;
    if (step_words.size() >= MAX_RESULTS) return;
    w.data = b;
    w.rec_last = last;
    w.run_last = 1'b0;
    step_words.push_back(w);
  endfunction

  function automatic void flush_sysex();
    for (int i = 0; i < sx_fill; i++) emit_word(sx_buf[i], i == sx_fill - 1);
    sx_fill = 0;
  endfunction

  // Advance the parser mirror by one byte, collecting the words it emits
  function automatic void frame_step(input logic [7:0] c);
    int want;
    byte_dropped = 1'b0;
    // realtime passes straight through
    if (c >= ST_CLOCK) begin
      emit_word(c, 1'b1);
      return;
    end
    // sysex start drops any buffered bytes and partial message
    if (c == ST_SYSEX) begin
      msg_fill = 0;
      run_status = 8'h00;
      sx_active = 1'b1;
      sx_buf[0] = c;
      sx_fill = 1;
      return;
    end
    if (sx_active) begin
      if (c == ST_EOX) begin
        if (sx_fill < SX_CHUNK) begin
          sx_buf[sx_fill] = c;
          sx_fill = sx_fill + 1;
        end
        flush_sysex();
        sx_active = 1'b0;
        return;
      end
      if (c[7]) begin
        flush_sysex();
        sx_active = 1'b0;
      end else begin
        if (sx_fill < SX_CHUNK) begin
          sx_buf[sx_fill] = c;
          sx_fill = sx_fill + 1;
        end
        if (sx_fill >= SX_CHUNK) flush_sysex();
        return;
      end
    end
    // status byte: start a message, one-byte ones go out now
    if (c[7]) begin
      msg_buf[0] = c;
      msg_fill = 1;
      run_status = (c < ST_SYSEX) ? c : 8'h00;
      if (msg_length(c) == 1) begin
        emit_word(c, 1'b1);
        msg_fill = 0;
      end
      return;
    end
    // data byte: resume running status or drop
    if (msg_fill == 0) begin
      if (run_status == 8'h00) begin
        byte_dropped = 1'b1;
        return;
      end
      msg_buf[0] = run_status;
      msg_fill = 1;
    end
    if (msg_fill < 3) begin
      msg_buf[msg_fill] = c;
      msg_fill = msg_fill + 1;
    end
    want = msg_length(msg_buf[0]);
    if (msg_fill >= want) begin
      for (int i = 0; i < want; i++) emit_word(msg_buf[i], i == want - 1);
      msg_fill = 0;
    end
  endfunction

  // Queue up the words an accepted byte should produce
  function automatic void predict_accept(input logic [7:0] c);
    midi_word_t w;
    step_words.delete();
    frame_step(c);
    if (step_words.size() > 0) begin
      w = step_words[step_words.size() - 1];
      w.run_last = 1'b1;
      step_words[step_words.size() - 1] = w;
    end
    foreach (step_words[i]) expected_words.push_back(step_words[i]);
    bytes_sent++;
    if (!byte_dropped) counted_bytes++;
  endfunction

  // ---------------------------------------------------------------------------
  // Result checker
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    midi_word_t exp_w;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_words.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("[%0t] unexpected word: byte=%02h rec_last=%0b run_last=%0b",
                   $realtime, out_byte, out_record_last, out_run_last);
      end else begin
        exp_w = expected_words.pop_front();
        words_checked++;
        if (out_record_last) records_checked++;
        if (out_byte !== exp_w.data || out_record_last !== exp_w.rec_last ||
            out_run_last !== exp_w.run_last) begin
          mismatches++;
          if (mismatches <= 10)
            $display("[%0t] word mismatch: exp %02h/%0b/%0b got %02h/%0b/%0b",
                     $realtime, exp_w.data, exp_w.rec_last, exp_w.run_last,
                     out_byte, out_record_last, out_run_last);
        end
      end
    end
  end

  // Receiver back-pressure, changed on the falling edge
  always @(negedge clk) begin
    out_stall = ($urandom_range(99) < recv_stall_pct);
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // Send one byte; entered and left at a falling edge
  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      in_byte = 8'($urandom);
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_byte = b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_accept(b);
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  // Occasionally slip a realtime byte in ahead of the real one
  task automatic send_mixed(input logic [7:0] b);
    if ($urandom_range(99) < 6) send_byte(8'($urandom_range(8'hFF, ST_CLOCK)));
    send_byte(b);
  endtask

  function automatic logic [7:0] rand_data();
    return 8'($urandom_range(8'h7F, 8'h00));
  endfunction

  // Channel status, or a non-sysex system common status
  function automatic logic [7:0] rand_status();
    if ($urandom_range(3) == 0) begin
      return ($urandom_range(1) == 0) ? 8'($urandom_range(8'hF6, ST_MTC))
                                      : 8'($urandom_range(8'hEF, ST_NOTE_OFF));
    end
    return 8'($urandom_range(8'hEF, ST_NOTE_OFF));
  endfunction

  task automatic send_message(input logic [7:0] s, input int n_data);
    send_mixed(s);
    for (int i = 0; i < n_data; i++) send_mixed(rand_data());
  endtask

  task automatic send_sysex_body(input int n_data);
    send_mixed(ST_SYSEX);
    for (int i = 0; i < n_data; i++) send_mixed(rand_data());
  endtask

  // One random sequence, mostly well formed
  task automatic random_sequence();
    int kind;
    int n;
    logic [7:0] s;
    kind = $urandom_range(99);
    if (kind < 30) begin
      s = 8'($urandom_range(8'hEF, ST_NOTE_OFF));
      send_message(s, msg_length(s) - 1);
    end else if (kind < 45) begin
      // running status continuation
      n = (run_status != 8'h00) ? msg_length(run_status) - 1 : $urandom_range(1, 2);
      for (int i = 0; i < n * $urandom_range(1, 3); i++) send_mixed(rand_data());
    end else if (kind < 55) begin
      s = 8'($urandom_range(ST_EOX, ST_MTC));
      send_message(s, msg_length(s) - 1);
    end else if (kind < 80) begin
      n = ($urandom_range(4) == 0) ? $urandom_range(25, 70) : $urandom_range(0, 12);
      send_sysex_body(n);
      case ($urandom_range(9))
        0: send_mixed(ST_SYSEX);
        1, 2: begin
          s = rand_status();
          send_message(s, msg_length(s) - 1);
        end
        default: send_mixed(ST_EOX);
      endcase
    end else if (kind < 90) begin
      // truncated message
      s = rand_status();
      n = msg_length(s) - 1;
      send_message(s, (n > 0) ? $urandom_range(n - 1) : 0);
    end else begin
      n = $urandom_range(1, 4);
      for (int i = 0; i < n; i++) send_byte(8'($urandom));
    end
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Data with no status is dropped
  task automatic test_stray_data();
    send_byte(8'h00);
    send_byte(8'h7F);
  endtask

  task automatic test_channel_messages();
    send_byte(ST_NOTE_OFF);
    send_byte(8'h00);
    send_byte(8'h7F);
    send_byte(8'hCF);
    send_byte(8'h7F);
    send_byte(8'h00);          // running status, program change
    send_byte(8'hE5);
    send_byte(8'h7F);
    send_byte(8'hF8);          // realtime inside a partial message
    send_byte(8'h00);
    send_byte(8'h41);          // running status, pitch bend
    send_byte(8'h7F);
  endtask

  task automatic test_system_common();
    send_byte(ST_MTC);
    send_byte(8'h7F);
    send_byte(ST_SPP);
    send_byte(8'h00);
    send_byte(8'h7F);
    send_byte(8'hF6);
    send_byte(ST_EOX);         // lone end of sysex
    send_byte(8'h55);          // stray after running status was cleared
    send_byte(8'hFF);
  endtask

  task automatic test_sysex();
    // short dump with realtime inside
    send_byte(ST_SYSEX);
    send_byte(8'h7E);
    send_byte(8'hFE);
    send_byte(ST_EOX);
    // restart discards the first buffer
    send_byte(ST_SYSEX);
    send_byte(8'h01);
    send_byte(ST_SYSEX);
    send_byte(8'h02);
    send_byte(ST_EOX);
    // full record at the cap, then a short tail
    send_byte(ST_SYSEX);
    for (int i = 0; i < SX_CHUNK - 1; i++) send_byte(8'(i * 4));
    send_byte(8'h33);
    send_byte(ST_EOX);
    // nearly full buffer interrupted by a one-byte status: most words per byte
    send_byte(ST_SYSEX);
    for (int i = 0; i < SX_CHUNK - 2; i++) send_byte(8'(8'h7F - i));
    send_byte(8'hF6);
    // interrupted by a channel message
    send_byte(ST_SYSEX);
    send_byte(8'h11);
    send_byte(8'h93);
    send_byte(8'h3C);
    send_byte(8'h40);
  endtask

  task automatic test_random_traffic(input int idle_pct, input int stall_pct);
    int start_count;
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    start_count = counted_bytes;
    while (counted_bytes - start_count < RANDOM_PER_PHASE) random_sequence();
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    int waited;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_byte = 8'h00;
    out_stall = 1'b0;
    repeat (9) @(negedge clk);
    rst_n = 1'b1;

    test_stray_data();
    test_channel_messages();
    test_system_common();
    test_sysex();
    test_random_traffic(0, 0);
    test_random_traffic(59, 0);
    test_random_traffic(0, 59);
    test_random_traffic(27, 27);

    // drain, then watch for stray words
    waited = 0;
    while (expected_words.size() > 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (expected_words.size() > 0) begin
      mismatches += expected_words.size();
      $display("%0d expected words never arrived", expected_words.size());
    end

    $display("Sent %0d bytes under four pacing modes; checked %0d words in %0d records.",
             bytes_sent, words_checked, records_checked);
    $display("Mismatches: %0d", mismatches);
    if (mismatches == 0) begin
      $display("midi_message_framer_core_tb OK");
    end else begin
      $display("midi_message_framer_core_tb NOT OK");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #5_000_000;
    $display("midi_message_framer_core_tb NOT OK");
    $finish;
  end

endmodule
